@@ src/kdcd_pkg.sv @@
// ----------------------------------------------------------------------------
// kdcd_pkg
// Shared types and constants for the key debounce and click detector.
// ----------------------------------------------------------------------------
package kdcd_pkg;

  // Number of keys handled in parallel, and the width of the raw level field
  localparam int KEYS  = 6;
  localparam int RAW_W = 6;

  // Field widths
  localparam int FLAG_W  = 6;
  localparam int SEL_W   = 3;
  localparam int DEB_W   = 8;
  localparam int TIMER_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Flag bit positions
  localparam int FLAG_HOLD   = 0;
  localparam int FLAG_DOWN   = 1;
  localparam int FLAG_UP     = 2;
  localparam int FLAG_SINGLE = 3;
  localparam int FLAG_DOUBLE = 4;
  localparam int FLAG_LONG   = 5;

  // Command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 8'd10;
  localparam logic [TIMER_W-1:0] LONG_RESET     = 16'd1000;
  localparam logic [TIMER_W-1:0] DOUBLE_RESET   = 16'd300;

  // Per-key press stage
  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_PRESSED = 5'b00010,
    ST_WAIT    = 5'b00100,
    ST_DOUBLE  = 5'b01000,
    ST_LONG    = 5'b10000
  } stage_t;

  // One result beat
  typedef struct packed {
    logic              hit;
    logic [FLAG_W-1:0] key_flags;
    logic [RAW_W-1:0]  stable_keys;
  } result_t;

endpackage

@@ src/key_debounce_click_detector_top.sv @@
// ----------------------------------------------------------------------------
// key_debounce_click_detector_top
// Multi-key debounce with hold/down/up flags and single, double and long
// press detection; check beats test and clear one key's sticky flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): command 0 is a tick carrying the raw
//   key levels in raw_keys; command 1 checks key key_select against flag_mask
//   and clears the masked flags that were set.
//   Output channel (out_valid / out_stall): one result beat per input beat,
//   in order: hit, key_flags and the debounced stable_keys after the beat.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; index
//   0 debounce ticks, 1 long press ticks, 2 double click window; others are
//   ignored. Write only while idle.
//   Results are registered: shown the cycle after the beat is taken, behind any waiting result.
//   Throughput: one beat per cycle while in_stall is low; all per-key state
//   updates in the cycle of acceptance, set by the single pass of per-key logic.
//   A two-entry result buffer parts the channels: input keeps flowing while
//   one result waits; in_stall rises only when both entries are full.
//   Reset (rst, synchronous) clears all key state and the buffer and loads
//   the register defaults (10, 1000, 300). No clearing pass is needed.
// ----------------------------------------------------------------------------
module key_debounce_click_detector_top import kdcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [RAW_W-1:0]      raw_keys,
  input  logic [SEL_W-1:0]      key_select,
  input  logic [FLAG_W-1:0]     flag_mask,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  hit,
  output logic [FLAG_W-1:0]     key_flags,
  output logic [RAW_W-1:0]      stable_keys,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [DEB_W-1:0]   debounce_ticks;
  logic [TIMER_W-1:0] long_press_ticks;
  logic [TIMER_W-1:0] double_click_ticks;

  // Per-key state
  stage_t             stage [KEYS];
  logic [TIMER_W-1:0] timer [KEYS];
  logic [KEYS-1:0]    stable_level;
  logic [DEB_W-1:0]   disagree [KEYS];
  logic [FLAG_W-1:0]  flags [KEYS];

  stage_t             stage_next [KEYS];
  logic [TIMER_W-1:0] timer_next [KEYS];
  logic [KEYS-1:0]    stable_level_next;
  logic [DEB_W-1:0]   disagree_next [KEYS];
  logic [FLAG_W-1:0]  flags_next [KEYS];

  // Result buffer
  result_t            rbuf [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  result_t            res_next;

  logic               push;
  logic               pop;
  logic [KEYS-1:0]    raw_ext;
  logic               sel_ok;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign raw_ext   = KEYS'(raw_keys);
  assign sel_ok    = (32'(key_select) < KEYS);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= DEBOUNCE_RESET;
      long_press_ticks   <= LONG_RESET;
      double_click_ticks <= DOUBLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_ticks     <= cfg_data[DEB_W-1:0];
        CFG_LONG:     long_press_ticks   <= cfg_data[TIMER_W-1:0];
        CFG_DOUBLE:   double_click_ticks <= cfg_data[TIMER_W-1:0];
        default:      ;
      endcase
    end
  end

  // Per-key next state: tick or check, one pass
  always_comb begin
    logic [TIMER_W-1:0] tdec;
    logic [DEB_W-1:0]   cinc;
    logic               lvl;
    logic               pressed;
    logic [FLAG_W-1:0]  f;
    for (int k = 0; k < KEYS; k++) begin
      stage_next[k]        = stage[k];
      timer_next[k]        = timer[k];
      stable_level_next[k] = stable_level[k];
      disagree_next[k]     = disagree[k];
      flags_next[k]        = flags[k];
      tdec    = (timer[k] != '0) ? timer[k] - 1'b1 : timer[k];
      cinc    = disagree[k] + 1'b1;
      lvl     = raw_ext[k];
      pressed = stable_level[k];
      f       = flags[k];
      if (command == CMD_TICK) begin
        // debounce
        timer_next[k] = tdec;
        if (lvl == stable_level[k]) begin
          disagree_next[k] = '0;
        end else if (cinc >= debounce_ticks) begin
          pressed          = lvl;
          disagree_next[k] = '0;
        end else begin
          disagree_next[k] = cinc;
        end
        stable_level_next[k] = pressed;
        // level flags
        f[FLAG_HOLD] = pressed;
        if (pressed && !stable_level[k]) begin
          f[FLAG_DOWN] = 1'b1;
        end else if (!pressed && stable_level[k]) begin
          f[FLAG_UP] = 1'b1;
        end
        // press stage machine
        unique case (stage[k])
          ST_IDLE: begin
            if (pressed) begin
              stage_next[k] = ST_PRESSED;
              timer_next[k] = long_press_ticks;
            end
          end
          ST_PRESSED: begin
            if (!pressed) begin
              stage_next[k] = ST_WAIT;
              timer_next[k] = double_click_ticks;
            end else if (tdec == '0) begin
              f[FLAG_LONG]  = 1'b1;
              stage_next[k] = ST_LONG;
            end
          end
          ST_WAIT: begin
            if (tdec == '0) begin
              f[FLAG_SINGLE] = 1'b1;
              stage_next[k]  = ST_IDLE;
            end else if (pressed) begin
              f[FLAG_DOUBLE] = 1'b1;
              stage_next[k]  = ST_DOUBLE;
            end
          end
          ST_DOUBLE, ST_LONG: begin
            if (!pressed) begin
              stage_next[k] = ST_IDLE;
            end
          end
          default: stage_next[k] = ST_IDLE;
        endcase
        flags_next[k] = f;
      end else if (sel_ok && (32'(key_select) == k) && ((flags[k] & flag_mask) != '0)) begin
        // check hit: clear the masked flags
        flags_next[k] = flags[k] & ~flag_mask;
      end
    end
  end

  // Result of the beat being taken
  always_comb begin
    res_next.hit         = 1'b0;
    res_next.key_flags   = '0;
    res_next.stable_keys = RAW_W'(stable_level_next);
    if ((command == CMD_CHECK) && sel_ok) begin
      res_next.hit       = (flags[key_select] & flag_mask) != '0;
      res_next.key_flags = flags_next[key_select];
    end
  end

  // Key state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= '0;
      for (int k = 0; k < KEYS; k++) begin
        stage[k]    <= ST_IDLE;
        timer[k]    <= '0;
        disagree[k] <= '0;
        flags[k]    <= '0;
      end
    end else if (push) begin
      stable_level <= stable_level_next;
      for (int k = 0; k < KEYS; k++) begin
        stage[k]    <= stage_next[k];
        timer[k]    <= timer_next[k];
        disagree[k] <= disagree_next[k];
        flags[k]    <= flags_next[k];
      end
    end
  end

  // Result buffer pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Result buffer storage
  always_ff @(posedge clk) begin
    if (push) begin
      rbuf[wr_ptr] <= res_next;
    end
  end

  assign hit         = rbuf[rd_ptr].hit;
  assign key_flags   = rbuf[rd_ptr].key_flags;
  assign stable_keys = rbuf[rd_ptr].stable_keys;

`ifndef SYNTHESIS
  // buffer never overfills
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result buffer count out of range");

  // every taken beat leaves a result to deliver
  a_push_valid: assert property (@(posedge clk) disable iff (rst) push |=> out_valid)
    else $error("accepted beat produced no result");

  // a tick never reports a hit or flags
  a_tick_quiet: assert property (@(posedge clk) disable iff (rst)
    (push && command == CMD_TICK) |-> (!res_next.hit && res_next.key_flags == '0))
    else $error("tick produced check fields");

  // a hit always leaves the masked flags clear
  a_hit_clears: assert property (@(posedge clk) disable iff (rst)
    (push && res_next.hit) |-> ((res_next.key_flags & flag_mask) == '0))
    else $error("hit left masked flags set");
`endif

endmodule
